// ----- rtl/rofp_pkg.sv -----
// ----------------------------------------------------------------------------
// rofp_pkg
// Shared constants, codes and types of the rectangle outline/fill painter.
// ----------------------------------------------------------------------------
package rofp_pkg;

    // canvas geometry and fixed point format
    localparam int MAX_SIDE  = 256;
    localparam int FRAC_BITS = 8;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int CNT_W     = SIDE_W + 1;
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;

    // input field widths
    localparam int KIND_W  = 2;
    localparam int POS_W   = 20;
    localparam int SIZE_W  = 19;
    localparam int BYTE_W  = 8;
    localparam int RDPOS_W = 8;

    // coordinate width: holds corner + size and a scaled pixel index
    localparam int CW_A = POS_W + 2;
    localparam int CW_B = SIDE_W + FRAC_BITS + 2;
    localparam int CW   = (CW_A > CW_B) ? CW_A : CW_B;
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_SIZE_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // stream packing
    localparam int IN_FIELDS_W = 1 + 2 * POS_W + 2 * SIZE_W + BYTE_W + 2 * RDPOS_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 16;

    localparam int OFS_FILLED = 0;
    localparam int OFS_LEFT   = 1;
    localparam int OFS_TOP    = OFS_LEFT + POS_W;
    localparam int OFS_RW     = OFS_TOP + POS_W;
    localparam int OFS_RH     = OFS_RW + SIZE_W;
    localparam int OFS_PAINT  = OFS_RH + SIZE_W;
    localparam int OFS_COL    = OFS_PAINT + BYTE_W;
    localparam int OFS_ROW    = OFS_COL + RDPOS_W;

    // rectangle bounds and border thresholds, all in fixed point
    typedef struct packed {
        logic signed [CW-1:0] lft;
        logic signed [CW-1:0] lft_in;
        logic signed [CW-1:0] rgt;
        logic signed [CW-1:0] rgt_in;
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] top_in;
        logic signed [CW-1:0] bot;
        logic signed [CW-1:0] bot_in;
        logic                 filled;
    } rect_t;

endpackage

// ----- rtl/rofp_ram.sv -----
// ----------------------------------------------------------------------------
// rofp_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module rofp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/rofp_pixel_test.sv -----
// ----------------------------------------------------------------------------
// rofp_pixel_test
// Shared compare unit: classifies one pixel against the current rectangle.
// ----------------------------------------------------------------------------
module rofp_pixel_test (
    input  rofp_pkg::rect_t             rect_i,
    input  logic [rofp_pkg::SIDE_W-1:0] x_i,
    input  logic [rofp_pkg::SIDE_W-1:0] y_i,
    output logic                        paint_o
);
    import rofp_pkg::*;

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 in_rect;
    logic                 border;

    // pixel index scaled to fixed point, always non-negative
    assign px = signed'(CW'({x_i, {FRAC_BITS{1'b0}}}));
    assign py = signed'(CW'({y_i, {FRAC_BITS{1'b0}}}));

    assign in_rect = (px >= rect_i.lft) && (px <= rect_i.rgt) &&
                     (py >= rect_i.top) && (py <= rect_i.bot);

    // within 1.0 of an edge
    assign border = (px < rect_i.lft_in) || (px > rect_i.rgt_in) ||
                    (py < rect_i.top_in) || (py > rect_i.bot_in);

    assign paint_o = in_rect && (border || rect_i.filled);

endmodule

// ----- rtl/rectangle_outline_fill_painter.sv -----
// ----------------------------------------------------------------------------
// rectangle_outline_fill_painter
// Clear and draw visit every pixel of the active canvas (W, H = active size),
//   one pixel visited per cycle through the single canvas RAM port, then pass
//   through ST_FINISH; a rejected draw, an empty canvas or an unused kind go
//   straight to ST_FINISH; a read passes ST_RD_ISSUE and ST_RD_WAIT first.
// One item at a time; s_tready is high only in idle. The result register
//   lets the next item start while a result waits on m_tready.
// Reset (aresetn, sync, active low): sequencer idle, no result pending,
//   config back to 256 x 256, background 0x20. Canvas RAM is not cleared.
// ----------------------------------------------------------------------------
module rectangle_outline_fill_painter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_we,
    input  logic [rofp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rofp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: filled, rect_left, rect_top, rect_width, rect_height,
    //        paint_byte, read_column, read_row, zero pad
    input  logic [rofp_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: kind
    input  logic [rofp_pkg::KIND_W-1:0]         s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: status, pixel_byte, zero pad
    output logic [rofp_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import rofp_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_RD_ISSUE = 3'd2;
    localparam logic [2:0] ST_RD_WAIT  = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [CFG_SIZE_W-1:0] cfg_width_reg;
    logic [CFG_SIZE_W-1:0] cfg_height_reg;
    logic [BYTE_W-1:0]     bg_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= CFG_SIZE_W'(256);
            cfg_height_reg <= CFG_SIZE_W'(256);
            bg_byte_reg    <= BYTE_W'(32);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_width_reg  <= cfg_wdata[CFG_SIZE_W-1:0];
                CFG_HEIGHT: cfg_height_reg <= cfg_wdata[CFG_SIZE_W-1:0];
                CFG_BG:     bg_byte_reg    <= cfg_wdata[BYTE_W-1:0];
                default:    ;
            endcase
        end
    end

    // active area, saturated at the store side
    logic [CNT_W-1:0] w_act;
    logic [CNT_W-1:0] h_act;

    assign w_act = (32'(cfg_width_reg) > 32'(MAX_SIDE)) ? CNT_W'(MAX_SIDE)
                                                        : CNT_W'(cfg_width_reg);
    assign h_act = (32'(cfg_height_reg) > 32'(MAX_SIDE)) ? CNT_W'(MAX_SIDE)
                                                         : CNT_W'(cfg_height_reg);

    // ------------------------------------------------------------------
    // Input beat unpacking
    // ------------------------------------------------------------------
    logic                     in_filled;
    logic signed [POS_W-1:0]  in_left;
    logic signed [POS_W-1:0]  in_top;
    logic [SIZE_W-1:0]        in_rw;
    logic [SIZE_W-1:0]        in_rh;
    logic [BYTE_W-1:0]        in_paint;
    logic [RDPOS_W-1:0]       in_col;
    logic [RDPOS_W-1:0]       in_row;

    assign in_filled = s_tdata[OFS_FILLED];
    assign in_left   = signed'(s_tdata[OFS_LEFT +: POS_W]);
    assign in_top    = signed'(s_tdata[OFS_TOP +: POS_W]);
    assign in_rw     = s_tdata[OFS_RW +: SIZE_W];
    assign in_rh     = s_tdata[OFS_RH +: SIZE_W];
    assign in_paint  = s_tdata[OFS_PAINT +: BYTE_W];
    assign in_col    = s_tdata[OFS_COL +: RDPOS_W];
    assign in_row    = s_tdata[OFS_ROW +: RDPOS_W];

    // bounds and border thresholds computed once per draw beat
    rect_t                rect_in;
    logic signed [CW-1:0] lft_ext;
    logic signed [CW-1:0] top_ext;
    logic signed [CW-1:0] rgt_ext;
    logic signed [CW-1:0] bot_ext;

    assign lft_ext = CW'(in_left);
    assign top_ext = CW'(in_top);
    assign rgt_ext = lft_ext + signed'(CW'(in_rw));
    assign bot_ext = top_ext + signed'(CW'(in_rh));

    always_comb begin
        rect_in.lft    = lft_ext;
        rect_in.lft_in = lft_ext + ONE;
        rect_in.rgt    = rgt_ext;
        rect_in.rgt_in = rgt_ext - ONE;
        rect_in.top    = top_ext;
        rect_in.top_in = top_ext + ONE;
        rect_in.bot    = bot_ext;
        rect_in.bot_in = bot_ext - ONE;
        rect_in.filled = in_filled;
    end

    logic rd_in_range;
    assign rd_in_range = (32'(in_col) < 32'(MAX_SIDE)) && (32'(in_row) < 32'(MAX_SIDE));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [2:0]        state_reg, state_next;
    logic [SIDE_W-1:0] x_reg, x_next;
    logic [SIDE_W-1:0] y_reg, y_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]  h_reg, h_next;
    logic              is_clear_reg, is_clear_next;
    rect_t             rect_reg, rect_next;
    logic [BYTE_W-1:0] paint_reg, paint_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic              res_status_reg, res_status_next;
    logic [BYTE_W-1:0] res_pixel_reg, res_pixel_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [BYTE_W-1:0] m_pixel_reg, m_pixel_next;

    logic              accept;
    logic              area_empty;
    logic              last_col;
    logic              last_row;
    logic              pix_paint;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign area_empty = (w_act == '0) || (h_act == '0);
    assign last_col   = (({1'b0, x_reg} + CNT_W'(1)) == w_reg);
    assign last_row   = (({1'b0, y_reg} + CNT_W'(1)) == h_reg);

    rofp_pixel_test u_pixel_test (
        .rect_i  (rect_reg),
        .x_i     (x_reg),
        .y_i     (y_reg),
        .paint_o (pix_paint)
    );

    // canvas port: scan writes at (y, x), reads use the latched address
    assign ram_we    = (state_reg == ST_SCAN) && (is_clear_reg || pix_paint);
    assign ram_addr  = (state_reg == ST_SCAN) ? {y_reg, x_reg} : rd_addr_reg;
    assign ram_wdata = is_clear_reg ? bg_byte_reg : paint_reg;

    rofp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        is_clear_next   = is_clear_reg;
        rect_next       = rect_reg;
        paint_next      = paint_reg;
        rd_addr_next    = rd_addr_reg;
        res_status_next = res_status_reg;
        res_pixel_next  = res_pixel_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_pixel_next    = m_pixel_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x_next          = '0;
                    y_next          = '0;
                    w_next          = w_act;
                    h_next          = h_act;
                    rect_next       = rect_in;
                    paint_next      = in_paint;
                    rd_addr_next    = {SIDE_W'(in_row), SIDE_W'(in_col)};
                    res_status_next = 1'b0;
                    res_pixel_next  = '0;
                    state_next      = ST_FINISH;
                    case (s_tuser)
                        KIND_CLEAR: begin
                            is_clear_next = 1'b1;
                            if (!area_empty) begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_DRAW: begin
                            is_clear_next = 1'b0;
                            if ((in_rw == '0) || (in_rh == '0)) begin
                                res_status_next = 1'b1;   // zero-size rectangle
                            end else if (!area_empty) begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_READ: begin
                            if (rd_in_range) begin
                                state_next = ST_RD_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (last_col) begin
                    x_next = '0;
                    if (last_row) begin
                        state_next = ST_FINISH;
                    end else begin
                        y_next = y_reg + SIDE_W'(1);
                    end
                end else begin
                    x_next = x_reg + SIDE_W'(1);
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                res_pixel_next = ram_rdata;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                // hand result to output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pixel_next  = res_pixel_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        is_clear_reg   <= is_clear_next;
        rect_reg       <= rect_next;
        paint_reg      <= paint_next;
        rd_addr_reg    <= rd_addr_next;
        res_status_reg <= res_status_next;
        res_pixel_reg  <= res_pixel_next;
        m_status_reg   <= m_status_next;
        m_pixel_reg    <= m_pixel_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({m_pixel_reg, m_status_reg});

endmodule
